FILE: rtl/wbct_pkg.sv
// Shared types and constants for the work/break cycle timer.
// No dependencies; imported by every module of the block.
package wbct_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_PAUSE = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_SKIP  = 3'd4
  } cmd_e;

  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_RUNNING = 2'd1;
  localparam logic [1:0] RUN_PAUSED  = 2'd2;

  localparam logic PHASE_WORK  = 1'b0;
  localparam logic PHASE_BREAK = 1'b1;

  localparam logic [31:0] GAP_LIMIT = 32'd60;
  localparam logic [7:0]  LOOP_MAX  = 8'hFF;
  localparam logic [1:0]  TONE_BAD  = 2'd3;

  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_WORK_SPAN  = 3'd0,
    REG_BREAK_SPAN = 3'd1,
    REG_LOOP_ON    = 3'd2,
    REG_LOOP_LIMIT = 3'd3,
    REG_SOUND_EN   = 3'd4,
    REG_TONE_SEL   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] work_span;
    logic [15:0] break_span;
    logic        loop_on;
    logic [6:0]  loop_limit;
    logic        sound_en;
    logic [1:0]  tone_sel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  sound_choice;
    logic        sound_event;
    logic [7:0]  loops_done;
    logic [15:0] remaining_seconds;
    logic        phase;
    logic [1:0]  run_state;
  } result_t;

endpackage

FILE: rtl/work_break_cycle_timer.sv
// Work/break cycle timer top level: input register, update core, result register.
// Depends on wbct_pkg, wbct_cfg and wbct_core.
//
//   port group   dir  contents
//   s_axis_*     in   command word: tdata[2:0] command, [34:3] now_seconds
//   m_axis_*     out  status word: run_state, phase, remaining, loops, sound
//   APB p*       in   six config registers at byte address 4*index
//
// One word per cycle while the output is not stalled; an accepted word goes into the input
// register, then through the core update into the result register.
// Timer state changes when a word moves from the input to the output register.
// A stalled output holds the result; the input register takes a word while empty
// or while its own word moves on. Reset clears state and sets config to its defaults.
module work_break_cycle_timer import wbct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // [2:0] command, [34:3] now_seconds, rest 0
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // [1:0] run_state, [2] phase,
                                           // [18:3] remaining_seconds, [26:19] loops_done,
                                           // [27] sound_event, [29:28] sound_choice, rest 0
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [31:0] now_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res;
  cfg_t        cfg;
  logic        advance;
  logic        in_take;

  assign pready        = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  wbct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  wbct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .now_i  (now_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= s_axis_tdata[2:0];
      now_q <= s_axis_tdata[34:3];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, res_q};

endmodule

FILE: rtl/wbct_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on wbct_pkg for the register map and the cfg_t bundle.
module wbct_cfg import wbct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.work_span  <= 16'd1500;
      cfg_q.break_span <= 16'd300;
      cfg_q.loop_on    <= 1'b0;
      cfg_q.loop_limit <= 7'd4;
      cfg_q.sound_en   <= 1'b1;
      cfg_q.tone_sel   <= 2'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WORK_SPAN:  cfg_q.work_span  <= pwdata[15:0];
        REG_BREAK_SPAN: cfg_q.break_span <= pwdata[15:0];
        REG_LOOP_ON:    cfg_q.loop_on    <= pwdata[0];
        REG_LOOP_LIMIT: cfg_q.loop_limit <= pwdata[6:0];
        REG_SOUND_EN:   cfg_q.sound_en   <= pwdata[0];
        REG_TONE_SEL:   cfg_q.tone_sel   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WORK_SPAN:  prdata = {16'd0, cfg_q.work_span};
      REG_BREAK_SPAN: prdata = {16'd0, cfg_q.break_span};
      REG_LOOP_ON:    prdata = {31'd0, cfg_q.loop_on};
      REG_LOOP_LIMIT: prdata = {25'd0, cfg_q.loop_limit};
      REG_SOUND_EN:   prdata = {31'd0, cfg_q.sound_en};
      REG_TONE_SEL:   prdata = {30'd0, cfg_q.tone_sel};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/wbct_core.sv
// Timer state registers and the combinational command update.
// Depends on wbct_pkg for commands, run codes and the result bundle.
module wbct_core import wbct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output result_t     res_o
);

  logic [1:0]  run_q, run_d;
  logic        ph_q, ph_d;
  logic [16:0] el_q, el_d;
  logic [31:0] last_q, last_d;
  logic [7:0]  loop_q, loop_d;

  logic        halt;
  logic        sound;
  logic [7:0]  loop_inc;
  logic        loop_stop;
  logic [31:0] gap;
  logic [16:0] el_sum;
  logic [15:0] span_now;
  logic [15:0] span_new;
  cmd_e        cmd;

  assign cmd = cmd_e'(cmd_i);

  always_comb begin
    run_d     = run_q;
    ph_d      = ph_q;
    el_d      = el_q;
    last_d    = last_q;
    loop_d    = loop_q;
    halt      = 1'b0;
    sound     = 1'b0;
    loop_inc  = (loop_q == LOOP_MAX) ? loop_q : loop_q + 8'd1;
    loop_stop = !cfg_i.loop_on ||
                ((cfg_i.loop_limit != 7'd0) && (loop_inc >= {1'b0, cfg_i.loop_limit}));
    gap       = now_i - last_q;
    el_sum    = el_q + gap[16:0];
    span_now  = ph_q ? cfg_i.break_span : cfg_i.work_span;

    unique case (cmd)
      CMD_TICK: begin
        if (run_q == RUN_RUNNING) begin
          if (gap > GAP_LIMIT) begin
            halt = 1'b1;
          end else begin
            el_d   = el_sum;
            last_d = now_i;
            if (el_sum >= {1'b0, span_now}) begin
              el_d  = '0;
              ph_d  = ~ph_q;
              sound = cfg_i.sound_en;
              if (ph_q == PHASE_BREAK) begin
                loop_d = loop_inc;
                if (loop_stop) begin
                  halt   = 1'b1;
                  last_d = last_q;
                end
              end
            end
          end
        end
      end
      CMD_START: begin
        run_d  = RUN_RUNNING;
        last_d = now_i;
      end
      CMD_PAUSE: begin
        if (run_q != RUN_STOPPED) run_d = RUN_PAUSED;
      end
      CMD_STOP: halt = 1'b1;
      CMD_SKIP: begin
        if (run_q != RUN_STOPPED) begin
          last_d = now_i;
          el_d   = '0;
          ph_d   = ~ph_q;
          if (ph_q == PHASE_BREAK) begin
            loop_d = loop_inc;
            halt   = loop_stop;
          end
          if (!halt && run_q == RUN_PAUSED) run_d = RUN_RUNNING;
        end
      end
      default: ;
    endcase

    if (halt) begin
      run_d  = RUN_STOPPED;
      ph_d   = PHASE_WORK;
      el_d   = '0;
      loop_d = '0;
    end

    span_new                  = ph_d ? cfg_i.break_span : cfg_i.work_span;
    res_o.run_state           = run_d;
    res_o.phase               = ph_d;
    res_o.loops_done          = loop_d;
    res_o.sound_event         = sound;
    res_o.sound_choice        = (sound && cfg_i.tone_sel != TONE_BAD) ? cfg_i.tone_sel : 2'd0;
    res_o.remaining_seconds   = 16'd0;
    if (run_d == RUN_RUNNING && {1'b0, span_new} > el_d) begin
      res_o.remaining_seconds = span_new - el_d[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= RUN_STOPPED;
      ph_q   <= PHASE_WORK;
      el_q   <= '0;
      last_q <= '0;
      loop_q <= '0;
    end else if (step_i) begin
      run_q  <= run_d;
      ph_q   <= ph_d;
      el_q   <= el_d;
      last_q <= last_d;
      loop_q <= loop_d;
    end
  end

  a_stopped_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q == RUN_STOPPED) |-> (ph_q == PHASE_WORK && el_q == 17'd0 && loop_q == 8'd0))
    else $error("stopped timer holds stale phase state");

  a_sound_phase_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.sound_event) |=> (el_q == 17'd0 && ph_q != $past(ph_q)))
    else $error("sound event without a phase change");

  a_remaining_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.remaining_seconds != 16'd0) |-> (run_d == RUN_RUNNING))
    else $error("remaining time shown while not running");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(last_q) && $stable(loop_q))
    else $error("timer state moved without a word");

endmodule

FILE: tb/sv/wbct_status_checker.sv
// Status checker for the work/break cycle timer: watches the command, status and APB
// channels, predicts each status word from its own copy of timer state and registers.
// Depends on wbct_pkg.
module wbct_status_checker import wbct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic              cmd_ready_i,
  input  logic [39:0]       cmd_data_i,  // [2:0] command, [34:3] now_seconds
  input  logic              stat_valid_i,
  input  logic              stat_ready_i,
  input  logic [31:0]       stat_data_i, // [1:0] run_state, [2] phase, [18:3] remaining,
                                         // [26:19] loops_done, [27] sound_event,
                                         // [29:28] sound_choice
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fault_count_o,
  output int                due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg_q;
  logic [1:0]  mode_q;
  logic        phase_q;
  logic [16:0] elapsed_q;
  logic [31:0] stamp_q;
  logic [7:0]  loops_q;

  result_t     status_due[$];
  result_t     got_w;
  result_t     want_w;

  int fault_count = 0;
  assign fault_count_o = fault_count;

  task automatic log_fault(input string what, input logic [31:0] got, input logic [31:0] want);
    fault_count++;
    $display("%0t ns: status mismatch on %s: got %0h, expected %0h", $realtime, what, got,
             want);
  endtask

  function void halt_timer();
    mode_q    = RUN_STOPPED;
    phase_q   = PHASE_WORK;
    elapsed_q = '0;
    loops_q   = '0;
  endfunction

  // a finished break; returns 0 when the timer stops here
  function automatic bit close_loop();
    if (loops_q != LOOP_MAX)
      loops_q = loops_q + 8'd1;
    if (!cfg_q.loop_on || (cfg_q.loop_limit != 7'd0 && loops_q >= {1'b0, cfg_q.loop_limit}))
    begin
      halt_timer();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t advance_timer(input logic [2:0] op, input logic [31:0] stamp);
    result_t     r;
    logic [31:0] gap;
    logic [15:0] span;
    bit          keep;
    r    = '0;
    keep = 1'b1;
    case (op)
      CMD_TICK: begin
        if (mode_q == RUN_RUNNING) begin
          gap = stamp - stamp_q;
          if (gap > GAP_LIMIT) begin
            halt_timer();
          end else begin
            elapsed_q = elapsed_q + gap[16:0];
            if (phase_q == PHASE_WORK) begin
              if (elapsed_q >= {1'b0, cfg_q.work_span}) begin
                elapsed_q     = '0;
                phase_q       = PHASE_BREAK;
                r.sound_event = cfg_q.sound_en;
              end
            end else if (elapsed_q >= {1'b0, cfg_q.break_span}) begin
              elapsed_q     = '0;
              phase_q       = PHASE_WORK;
              r.sound_event = cfg_q.sound_en;
              keep          = close_loop();
            end
            if (keep)
              stamp_q = stamp;
          end
        end
      end
      CMD_START: begin
        mode_q  = RUN_RUNNING;
        stamp_q = stamp;
      end
      CMD_PAUSE: begin
        if (mode_q != RUN_STOPPED)
          mode_q = RUN_PAUSED;
      end
      CMD_STOP: halt_timer();
      CMD_SKIP: begin
        if (mode_q != RUN_STOPPED) begin
          stamp_q   = stamp;
          elapsed_q = '0;
          if (phase_q == PHASE_WORK) begin
            phase_q = PHASE_BREAK;
          end else begin
            phase_q = PHASE_WORK;
            keep    = close_loop();
          end
          if (keep && mode_q == RUN_PAUSED)
            mode_q = RUN_RUNNING;
        end
      end
      default: ;
    endcase

    if (mode_q == RUN_RUNNING) begin
      span = (phase_q == PHASE_WORK) ? cfg_q.work_span : cfg_q.break_span;
      if ({1'b0, span} > elapsed_q)
        r.remaining_seconds = span - elapsed_q[15:0];
    end
    r.run_state  = mode_q;
    r.phase      = phase_q;
    r.loops_done = loops_q;
    if (r.sound_event && cfg_q.tone_sel != TONE_BAD)
      r.sound_choice = cfg_q.tone_sel;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.work_span  = 16'd1500;
      cfg_q.break_span = 16'd300;
      cfg_q.loop_on    = 1'b0;
      cfg_q.loop_limit = 7'd4;
      cfg_q.sound_en   = 1'b1;
      cfg_q.tone_sel   = 2'd0;
      halt_timer();
      stamp_q = '0;
      status_due.delete();
    end else begin
      if (stat_valid_i && stat_ready_i) begin
        if (status_due.size() == 0) begin
          log_fault("word with nothing due", stat_data_i, '0);
        end else begin
          want_w = status_due.pop_front();
          got_w  = result_t'(stat_data_i[29:0]);
          if (got_w.run_state !== want_w.run_state)
            log_fault("run_state", 32'(got_w.run_state), 32'(want_w.run_state));
          if (got_w.phase !== want_w.phase)
            log_fault("phase", 32'(got_w.phase), 32'(want_w.phase));
          if (got_w.remaining_seconds !== want_w.remaining_seconds)
            log_fault("remaining_seconds", 32'(got_w.remaining_seconds),
                      32'(want_w.remaining_seconds));
          if (got_w.loops_done !== want_w.loops_done)
            log_fault("loops_done", 32'(got_w.loops_done), 32'(want_w.loops_done));
          if (got_w.sound_event !== want_w.sound_event)
            log_fault("sound_event", 32'(got_w.sound_event), 32'(want_w.sound_event));
          if (got_w.sound_choice !== want_w.sound_choice)
            log_fault("sound_choice", 32'(got_w.sound_choice), 32'(want_w.sound_choice));
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        status_due.push_back(advance_timer(cmd_data_i[2:0], cmd_data_i[34:3]));
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_WORK_SPAN:  cfg_q.work_span  = pwdata[15:0];
          REG_BREAK_SPAN: cfg_q.break_span = pwdata[15:0];
          REG_LOOP_ON:    cfg_q.loop_on    = pwdata[0];
          REG_LOOP_LIMIT: cfg_q.loop_limit = pwdata[6:0];
          REG_SOUND_EN:   cfg_q.sound_en   = pwdata[0];
          REG_TONE_SEL:   cfg_q.tone_sel   = pwdata[1:0];
          default: ;
        endcase
      end
    end
    due_count_o = status_due.size();
  end

endmodule

FILE: tb/sv/work_break_cycle_timer_test.sv
// Top of the work/break cycle timer test: clock, reset, command stimulus, status-side
// backpressure, register setup and the verdict. Depends on wbct_pkg,
// work_break_cycle_timer and wbct_status_checker.
module work_break_cycle_timer_test import wbct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int SINK_HOLD   = 200;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata  = '0;  // [2:0] command, [34:3] now_seconds
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [1:0] run_state, [2] phase, [18:3] remaining,
                                          // [26:19] loops_done, [27] sound_event,
                                          // [29:28] sound_choice
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fault_count;
  int          due_count;
  int          src_rate  = 0;
  int          sink_rate = 0;
  bit          hold_sink = 1'b0;
  int          quiet     = 0;
  logic [31:0] wall      = '0;

  always #5 clk_i = ~clk_i;

  work_break_cycle_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  wbct_status_checker status_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_i   (s_axis_tready),
    .cmd_data_i    (s_axis_tdata),
    .stat_valid_i  (m_axis_tvalid),
    .stat_ready_i  (m_axis_tready),
    .stat_data_i   (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fault_count_o (fault_count),
    .due_count_o   (due_count)
  );

  // cycles with no word, no register access
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // status side backpressure
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val,
                           input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= $urandom_range(0, 1) ? (val | ($urandom & ~mask)) : val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_timer(input int unsigned work, input int unsigned brk,
                           input int unsigned auto_on, input int unsigned limit,
                           input int unsigned snd, input int unsigned tone);
    write_reg(REG_WORK_SPAN,  work,    32'hFFFF);
    write_reg(REG_BREAK_SPAN, brk,     32'hFFFF);
    write_reg(REG_LOOP_ON,    auto_on, 32'h1);
    write_reg(REG_LOOP_LIMIT, limit,   32'h7F);
    write_reg(REG_SOUND_EN,   snd,     32'h1);
    write_reg(REG_TONE_SEL,   tone,    32'h3);
  endtask

  task automatic send_word(input logic [2:0] op, input logic [31:0] stamp);
    if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, stamp, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // tidy: only tick, skip, start and pause, with gaps of at most 60
  task automatic next_word(input bit tidy, output logic [2:0] op, output logic [31:0] stamp);
    int unsigned r;
    int unsigned pick;
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (tidy) begin
      if (r < 85) begin
        op   = CMD_TICK;
        wall = wall + $urandom_range(0, 60);
      end else if (r < 95) begin
        op   = CMD_SKIP;
        wall = wall + $urandom_range(0, 60);
      end else if (r < 98) begin
        op   = CMD_START;
        wall = wall + $urandom_range(0, 60);
      end else begin
        op = CMD_PAUSE;
      end
      stamp = wall;
    end else begin
      if (r < 72) begin
        op = CMD_TICK;
        if (pick < 50)
          wall = wall + $urandom_range(50, 60);
        else if (pick < 90)
          wall = wall + $urandom_range(0, 60);
        else if (pick < 93)
          wall = wall + 61;
        else if (pick < 96)
          wall = $urandom;
        else
          wall = wall - $urandom_range(1, 120);
        stamp = wall;
      end else if (r < 80) begin
        op = CMD_START;
        if (pick < 80)
          wall = wall + $urandom_range(0, 60);
        else if (pick < 90)
          wall = 32'hFFFF_FF80 + $urandom_range(0, 127);
        else
          wall = $urandom;
        stamp = wall;
      end else if (r < 84) begin
        op    = CMD_PAUSE;
        stamp = pick < 50 ? wall : $urandom;
      end else if (r < 87) begin
        op    = CMD_STOP;
        stamp = $urandom;
      end else if (r < 95) begin
        op    = CMD_SKIP;
        wall  = wall + $urandom_range(0, 60);
        stamp = wall;
      end else begin
        op    = 3'($urandom_range(5, 7));
        stamp = $urandom;
      end
    end
  endtask

  task automatic run_words(input int unsigned count, input bit tidy);
    logic [2:0]  op;
    logic [31:0] stamp;
    for (int unsigned i = 0; i < count; i++) begin
      next_word(tidy, op, stamp);
      send_word(op, stamp);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: short spans, looping on, tone 2
    src_rate  = 15;
    sink_rate = 15;
    set_timer(60, 60, 1, 2, 1, 2);
    send_word(CMD_TICK,  32'd0);           // ignored while stopped
    send_word(CMD_PAUSE, 32'd1);
    send_word(CMD_SKIP,  32'd2);
    send_word(CMD_STOP,  32'd3);
    send_word(CMD_START, 32'hFFFF_FFC4);
    send_word(CMD_TICK,  32'hFFFF_FFC4);   // gap 0
    send_word(CMD_TICK,  32'h0000_0000);   // gap 60, work ends
    send_word(CMD_TICK,  32'h0000_003C);   // break ends, loop counted
    send_word(CMD_TICK,  32'h0000_0079);   // gap 61, stops
    send_word(CMD_START, 32'h0000_0000);
    send_word(CMD_PAUSE, 32'h0000_0005);
    send_word(CMD_TICK,  32'h0000_000A);   // ignored while paused
    send_word(CMD_SKIP,  32'h0000_0014);   // resumes into break
    send_word(CMD_SKIP,  32'h0000_001E);   // loop counted
    send_word(CMD_TICK,  32'h0000_001D);   // clock ran backward, stops
    send_word(CMD_START, 32'hFFFF_FFFF);
    send_word(3'd5,      32'hAAAA_5555);
    send_word(3'd6,      32'h5555_AAAA);
    send_word(3'd7,      32'hFFFF_FFFF);
    send_word(CMD_PAUSE, 32'd0);
    send_word(CMD_START, 32'd40);
    send_word(CMD_STOP,  32'd41);
    drain();

    // span shrunk below the elapsed time, tone 3 with sound on
    set_timer(300, 60, 0, 4, 1, 3);
    send_word(CMD_START, 32'd1000);
    for (int i = 1; i <= 4; i++)
      send_word(CMD_TICK, 32'd1000 + 60 * i);
    drain();
    write_reg(REG_WORK_SPAN, 120, 32'hFFFF);
    send_word(3'd5,     32'd0);            // remaining reads 0
    send_word(CMD_TICK, 32'd1240);
    drain();

    // long receiver hold while commands keep coming
    wall      = $urandom;
    src_rate  = 20;
    sink_rate = 20;
    set_timer(60, 120, 1, 3, 1, 3);
    hold_sink = 1'b1;
    run_words(200, 1'b0);

    set_timer(65520, 16'hFFFF, 0, 127, 0, 1);
    run_words(100, 1'b0);

    // zero spans, unlimited loops: drives the loop count into saturation
    sink_rate = 10;
    src_rate  = 10;
    set_timer(0, 0, 1, 0, 1, 0);
    send_word(CMD_START, wall);
    run_words(650, 1'b1);

    for (int k = 0; k < 4; k++) begin
      src_rate  = (k == 1) ? 0 : 5 + 25 * (k % 2);
      sink_rate = (k == 2) ? 0 : 30 - 25 * (k % 2);
      set_timer(60 * $urandom_range(1, 6), 60 * $urandom_range(1, 3), $urandom_range(0, 1),
                (k == 3) ? 127 : $urandom_range(0, 100), $urandom_range(0, 1),
                $urandom_range(0, 3));
      run_words(120, 1'b0);
    end

    // closing stretch without idling
    src_rate  = 0;
    sink_rate = 0;
    set_timer(120, 60, 1, 100, 1, 1);
    run_words(100, 1'b0);

    repeat (8) @(posedge clk_i);
    if (fault_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wbct_pkg.sv
rtl/wbct_cfg.sv
rtl/wbct_core.sv
rtl/work_break_cycle_timer.sv
tb/sv/wbct_status_checker.sv
tb/sv/work_break_cycle_timer_test.sv
